// ----- rtl/core/swam_pkg.sv -----
// shared types and codes of the sliding window anagram matcher
package swam_pkg;

  localparam int KIND_W = 2;
  localparam int SYM_W  = 5;

  // request kinds on the input side
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd2;

  // operations handed from front to back
  localparam logic [1:0] OP_CLR = 2'd0;
  localparam logic [1:0] OP_PAT = 2'd1;
  localparam logic [1:0] OP_TXT = 2'd2;

  // depth of the op queue and of the result queue
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic [1:0]       op;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] leaving;
    logic             add_en;
    logic             rem_en;
    logic             full;
    logic             ovf;
  } swam_op_t;

  typedef struct packed {
    logic window_full;
    logic match_now;
    logic found;
    logic pattern_overflow;
  } swam_res_t;

endpackage

// ----- rtl/core/swam_fifo.sv -----
// small first-in first-out queue with registered storage
module swam_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/core/swam_front.sv -----
// front end: request intake, pattern and window bookkeeping, window symbol store
module swam_front #(
  parameter int MAX_PATTERN = 1024,
  parameter int ALPHABET    = 26
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [swam_pkg::KIND_W-1:0]    in_kind,
  input  logic [swam_pkg::SYM_W-1:0]     in_symbol,
  input  logic                           q_full,
  output logic                           q_push,
  output swam_pkg::swam_op_t             q_data
);
  import swam_pkg::*;

  localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
  localparam int AW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [PLEN_W-1:0] plen_r, plen_nxt;
  logic [PLEN_W-1:0] tseen_r, tseen_nxt;
  logic [AW-1:0]     wslot_r, wslot_nxt;
  logic              ovf_r, ovf_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  swam_op_t          s1_op_r, op_nxt;
  logic [SYM_W-1:0]  leave_r;
  logic [SYM_W-1:0]  win_mem [MAX_PATTERN];

  logic              accept, sym_ok, win_en, op_load, s1_adv, remove;
  logic [PLEN_W-1:0] slot_inc;

  assign s1_adv = s1_valid_r && !q_full;
  assign full   = s1_valid_r && q_full;
  assign accept = push && !full;
  assign sym_ok = int'(in_symbol) < ALPHABET;
  assign win_en = accept && (in_kind == KIND_TEXT) && sym_ok && (plen_r != '0);
  assign remove = (tseen_r >= plen_r);
  assign slot_inc = PLEN_W'(wslot_r) + PLEN_W'(1);

  always_comb begin
    plen_nxt  = plen_r;
    tseen_nxt = tseen_r;
    wslot_nxt = wslot_r;
    ovf_nxt   = ovf_r;
    op_load   = 1'b0;
    op_nxt    = '0;
    op_nxt.sym = in_symbol;
    if (accept) begin
      case (in_kind)
        KIND_CLEAR: begin
          plen_nxt  = '0;
          tseen_nxt = '0;
          wslot_nxt = '0;
          ovf_nxt   = 1'b0;
          op_load   = 1'b1;
          op_nxt.op = OP_CLR;
        end
        KIND_PAT: begin
          // pattern is frozen once text has begun
          if (sym_ok && (tseen_r == '0)) begin
            if (plen_r >= PLEN_W'(MAX_PATTERN)) begin
              ovf_nxt = 1'b1;
            end else begin
              plen_nxt  = plen_r + PLEN_W'(1);
              op_load   = 1'b1;
              op_nxt.op = OP_PAT;
            end
          end
        end
        KIND_TEXT: begin
          if (sym_ok) begin
            op_load   = 1'b1;
            op_nxt.op = OP_TXT;
            if (plen_r != '0) begin
              op_nxt.add_en = 1'b1;
              op_nxt.rem_en = remove;
              if (!remove) begin
                tseen_nxt = tseen_r + PLEN_W'(1);
              end
              wslot_nxt = (slot_inc >= plen_r) ? '0 : AW'(slot_inc);
            end
            op_nxt.full = (tseen_nxt >= plen_r);
            op_nxt.ovf  = ovf_r;
          end
        end
        default: begin
        end
      endcase
    end
    if (op_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    q_push         = s1_adv;
    q_data         = s1_op_r;
    q_data.leaving = leave_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r     <= '0;
      tseen_r    <= '0;
      wslot_r    <= '0;
      ovf_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      plen_r     <= plen_nxt;
      tseen_r    <= tseen_nxt;
      wslot_r    <= wslot_nxt;
      ovf_r      <= ovf_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_load) begin
      s1_op_r <= op_nxt;
    end
  end

  // read old symbol and write new one at the same slot
  always_ff @(posedge clk) begin
    if (win_en) begin
      leave_r          <= win_mem[wslot_r];
      win_mem[wslot_r] <= in_symbol;
    end
  end

  a_tseen_le_plen: assert property (@(posedge clk) disable iff (!rst_n)
    tseen_r <= plen_r)
    else $error("text count above pattern length");

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (plen_r != '0) |-> (PLEN_W'(wslot_r) < plen_r))
    else $error("write slot outside window");

  a_plen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= PLEN_W'(MAX_PATTERN))
    else $error("pattern length above capacity");

endmodule

// ----- rtl/core/swam_back.sv -----
// back end: per-letter histogram difference lanes, match and found tracking
module swam_back #(
  parameter int MAX_PATTERN = 1024,
  parameter int ALPHABET    = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  swam_pkg::swam_op_t  q_data,
  output logic                q_pop,
  input  logic                r_full,
  output logic                r_push,
  output swam_pkg::swam_res_t r_data
);
  import swam_pkg::*;

  localparam int DW = $clog2(MAX_PATTERN + 1) + 1;

  // window count minus pattern count, one lane per letter
  logic signed [DW-1:0] diff_r [ALPHABET];
  logic signed [DW-1:0] diff_nxt [ALPHABET];
  logic                 found_r, found_nxt;
  logic                 is_txt, all_zero, match, up, dn;

  assign is_txt = (q_data.op == OP_TXT);
  assign q_pop  = !q_empty && (!is_txt || !r_full);
  assign r_push = q_pop && is_txt;

  always_comb begin
    all_zero  = 1'b1;
    found_nxt = found_r;
    for (int l = 0; l < ALPHABET; l++) begin
      up = 1'b0;
      dn = 1'b0;
      case (q_data.op)
        OP_PAT: dn = (int'(q_data.sym) == l);
        OP_TXT: begin
          up = q_data.add_en && (int'(q_data.sym) == l);
          dn = q_data.rem_en && (int'(q_data.leaving) == l);
        end
        default: begin
        end
      endcase
      if (q_data.op == OP_CLR) begin
        diff_nxt[l] = '0;
      end else if (up && !dn) begin
        diff_nxt[l] = diff_r[l] + DW'(1);
      end else if (dn && !up) begin
        diff_nxt[l] = diff_r[l] - DW'(1);
      end else begin
        diff_nxt[l] = diff_r[l];
      end
      all_zero = all_zero && (diff_nxt[l] == '0);
    end
    match = q_data.full && all_zero;
    if (q_data.op == OP_CLR) begin
      found_nxt = 1'b0;
    end else if (is_txt && match) begin
      found_nxt = 1'b1;
    end
    r_data.window_full      = q_data.full;
    r_data.match_now        = match;
    r_data.found            = found_nxt;
    r_data.pattern_overflow = q_data.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < ALPHABET; l++) begin
        diff_r[l] <= '0;
      end
      found_r <= 1'b0;
    end else if (q_pop) begin
      for (int l = 0; l < ALPHABET; l++) begin
        diff_r[l] <= diff_nxt[l];
      end
      found_r <= found_nxt;
    end
  end

  a_clear_drops_found: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.op == OP_CLR) |=> !found_r)
    else $error("found flag survived a clear");

endmodule

// ----- rtl/core/sliding_window_anagram_matcher.sv -----
// a text request goes through the front stage register, the op queue and the result queue to the result ports
// throughput: one request per cycle; full rises only when the op queue and the
//   result queue both back up behind a stalled pop
// clear, pattern and dropped requests give no result
// reset clears the histogram difference lanes, counters, flags and both queues;
//   the window symbol store is not cleared, a stored symbol is only used once its slot is written
module sliding_window_anagram_matcher #(
  parameter int MAX_PATTERN = 1024,
  parameter int ALPHABET    = 26
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic [swam_pkg::KIND_W-1:0] in_kind,
  input  logic [swam_pkg::SYM_W-1:0]  in_symbol,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_window_full,
  output logic                        out_match_now,
  output logic                        out_found,
  output logic                        out_pattern_overflow
);
  import swam_pkg::*;

  localparam int OP_W  = $bits(swam_op_t);
  localparam int RES_W = $bits(swam_res_t);

  // front to op queue
  logic      fq_push, fq_full;
  swam_op_t  fq_data;
  // op queue to back
  logic      bq_empty, bq_pop;
  swam_op_t  bq_data;
  // back to result queue
  logic      r_push, r_full;
  swam_res_t r_data, r_head;

  // front: takes requests while not full, updates pattern length, text count and the
  // circular slot, and fetches the symbol leaving the window from the store
  swam_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_kind   (in_kind),
    .in_symbol (in_symbol),
    .q_full    (fq_full),
    .q_push    (fq_push),
    .q_data    (fq_data)
  );

  // short op queue so the front keeps taking requests while the back waits
  swam_fifo #(
    .WIDTH (OP_W),
    .DEPTH (Q_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (fq_full),
    .pop   (bq_pop),
    .rdata (bq_data),
    .empty (bq_empty)
  );

  // back: histogram lanes, match detect, sticky found flag
  swam_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (bq_empty),
    .q_data  (bq_data),
    .q_pop   (bq_pop),
    .r_full  (r_full),
    .r_push  (r_push),
    .r_data  (r_data)
  );

  // result queue, its head drives the result ports directly
  swam_fifo #(
    .WIDTH (RES_W),
    .DEPTH (Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .wdata (r_data),
    .full  (r_full),
    .pop   (pop),
    .rdata (r_head),
    .empty (empty)
  );

  assign out_window_full      = r_head.window_full;
  assign out_match_now        = r_head.match_now;
  assign out_found            = r_head.found;
  assign out_pattern_overflow = r_head.pattern_overflow;

  // a match is only reported on a full window
  a_match_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_match_now) |-> out_window_full)
    else $error("match reported on a partial window");

  // a match always shows up in the found flag of the same result
  a_match_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_match_now) |-> out_found)
    else $error("match without found flag");

endmodule
